FILE: hw/rtl/periodic_timer_slot_table_top_macros.svh
// Assertion macros of the timer slot table RTL, used by pts_seq.
// Needs a clock named clock and a synchronous reset named reset in scope.
`ifndef PERIODIC_TIMER_SLOT_TABLE_TOP_MACROS_SVH
`define PERIODIC_TIMER_SLOT_TABLE_TOP_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define PTS_ASSERT_NOW(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("timer slot table check failed");

// Next-cycle implication, checked outside reset.
`define PTS_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("timer slot table check failed");

`endif

FILE: hw/rtl/pts_pkg.sv
// Shared types and constants of the periodic timer slot table.
// No dependencies; every RTL module imports it.
`timescale 1ns / 1ps

package pts_pkg;

   localparam int NUM_SLOTS_DEFAULT  = 16;
   localparam int TIME_WIDTH_DEFAULT = 16;
   localparam int MAX_RESULTS        = 16;
   localparam int FIRE_CNT_W         = $clog2(MAX_RESULTS + 1);
   localparam int SLOT_FIELD_W       = 4;
   localparam int TIME_FIELD_W       = 16;

   typedef enum logic [1:0] {
      OP_REGISTER   = 2'd0,
      OP_SET_PERIOD = 2'd1,
      OP_CANCEL     = 2'd2,
      OP_TICK       = 2'd3
   } op_type;

   typedef struct packed {
      op_type                    operation;
      logic [SLOT_FIELD_W-1:0]   slot;
      logic [TIME_FIELD_W-1:0]   period;
      logic [TIME_FIELD_W-1:0]   delay;
      logic                      protect;
   } req_type;

   typedef struct packed {
      logic [SLOT_FIELD_W-1:0]   slot_number;
      logic                      accepted;
      logic                      fired;
      logic                      last;
   } rsp_type;

   // Memory port controls from the sequencer.
   typedef struct packed {
      logic rd_en;
      logic per_we;
      logic cnt_we;
   } mem_cmd_type;

   // In-use bit updates from the sequencer.
   typedef struct packed {
      logic set;
      logic clear;
   } alloc_cmd_type;

endpackage

FILE: hw/rtl/pts_mem.sv
// Slot storage: period memory and count/protect memory, registered read.
// Depends on pts_pkg.
`timescale 1ns / 1ps

module pts_mem #(
   parameter int NUM_SLOTS = pts_pkg::NUM_SLOTS_DEFAULT,
   parameter int TIME_W    = pts_pkg::TIME_WIDTH_DEFAULT,
   parameter int IDX_W     = 4
) (
   input  logic                clock,
   input  pts_pkg::mem_cmd_type cmd,
   input  logic [IDX_W-1:0]    rd_addr,
   input  logic [IDX_W-1:0]    wr_addr,
   input  logic [TIME_W-1:0]   per_wdata,
   input  logic [TIME_W-1:0]   cnt_wdata,
   input  logic                prot_wdata,
   output logic [TIME_W-1:0]   per_rdata,
   output logic [TIME_W-1:0]   cnt_rdata,
   output logic                prot_rdata
);
   import pts_pkg::*;

   logic [TIME_W-1:0] per_mem [NUM_SLOTS];
   logic [TIME_W:0]   cnt_mem [NUM_SLOTS];
   logic [TIME_W-1:0] per_q_ff;
   logic [TIME_W:0]   cnt_q_ff;

   // Period memory: write on register and set period, read during a tick sweep.
   always_ff @(posedge clock) begin
      if (cmd.per_we) begin
         per_mem[wr_addr] <= per_wdata;
      end
      if (cmd.rd_en) begin
         per_q_ff <= per_mem[rd_addr];
      end
   end

   // Count memory, protect flag in the top bit.
   always_ff @(posedge clock) begin
      if (cmd.cnt_we) begin
         cnt_mem[wr_addr] <= {prot_wdata, cnt_wdata};
      end
      if (cmd.rd_en) begin
         cnt_q_ff <= cnt_mem[rd_addr];
      end
   end

   assign per_rdata  = per_q_ff;
   assign cnt_rdata  = cnt_q_ff[TIME_W-1:0];
   assign prot_rdata = cnt_q_ff[TIME_W];

endmodule

FILE: hw/rtl/pts_alloc.sv
// In-use bits of the slots and the lowest-free-slot encoder.
// Depends on pts_pkg.
`timescale 1ns / 1ps

module pts_alloc #(
   parameter int NUM_SLOTS = pts_pkg::NUM_SLOTS_DEFAULT,
   parameter int IDX_W     = 4
) (
   input  logic                  clock,
   input  logic                  reset,
   input  pts_pkg::alloc_cmd_type cmd,
   input  logic [IDX_W-1:0]      cmd_idx,
   input  logic [IDX_W-1:0]      query_idx,
   output logic                  in_use_q,
   output logic                  free_found,
   output logic [IDX_W-1:0]      free_idx
);
   import pts_pkg::*;

   logic [NUM_SLOTS-1:0] in_use_ff;
   logic [NUM_SLOTS-1:0] in_use_in;

   always_comb begin
      in_use_in = in_use_ff;
      if (cmd.set) begin
         in_use_in[cmd_idx] = 1'b1;
      end
      if (cmd.clear) begin
         in_use_in[cmd_idx] = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_use_ff <= '0;
      end else begin
         in_use_ff <= in_use_in;
      end
   end

   // Lowest free slot wins.
   always_comb begin
      free_found = 1'b0;
      free_idx   = '0;
      for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
         if (!in_use_ff[i]) begin
            free_found = 1'b1;
            free_idx   = IDX_W'(i);
         end
      end
   end

   assign in_use_q = in_use_ff[query_idx];

endmodule

FILE: hw/rtl/pts_seq.sv
// Sequencer: table operations done in the cycle they are accepted, and the tick sweep over the slots.
// Depends on pts_pkg, pts_mem/pts_alloc signals and the assertion macros.
`timescale 1ns / 1ps
`include "periodic_timer_slot_table_top_macros.svh"

module pts_seq #(
   parameter int NUM_SLOTS = pts_pkg::NUM_SLOTS_DEFAULT,
   parameter int TIME_W    = pts_pkg::TIME_WIDTH_DEFAULT,
   parameter int IDX_W     = 4
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   input  pts_pkg::req_type       req_data,
   output logic                   req_ready,
   input  logic                   out_free,
   output logic                   out_load,
   output pts_pkg::rsp_type       out_data,
   output pts_pkg::mem_cmd_type   mem_cmd,
   output logic [IDX_W-1:0]       rd_addr,
   output logic [IDX_W-1:0]       wr_addr,
   output logic [TIME_W-1:0]      per_wdata,
   output logic [TIME_W-1:0]      cnt_wdata,
   output logic                   prot_wdata,
   input  logic [TIME_W-1:0]      per_rdata,
   input  logic [TIME_W-1:0]      cnt_rdata,
   input  logic                   prot_rdata,
   output pts_pkg::alloc_cmd_type alloc_cmd,
   output logic [IDX_W-1:0]       alloc_idx,
   output logic [IDX_W-1:0]       query_idx,
   input  logic                   in_use_q,
   input  logic                   free_found,
   input  logic [IDX_W-1:0]       free_idx
);
   import pts_pkg::*;

   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_SLOTS - 1);

   typedef enum logic [1:0] {
      S_IDLE,
      S_SWEEP,
      S_FLUSH
   } state_type;

   state_type               state_ff, state_in;
   logic                    issue_act_ff, issue_act_in;
   logic [IDX_W-1:0]        issue_idx_ff, issue_idx_in;
   logic                    proc_valid_ff, proc_valid_in;
   logic [IDX_W-1:0]        proc_idx_ff, proc_idx_in;
   logic                    held_valid_ff, held_valid_in;
   logic [SLOT_FIELD_W-1:0] held_slot_ff, held_slot_in;
   logic [FIRE_CNT_W-1:0]   fire_cnt_ff, fire_cnt_in;

   logic             req_acc;
   logic             slot_ok;
   logic [IDX_W-1:0] slot_idx;
   logic             proc_act;
   logic             cnt_zero;
   logic             cnt_fire;
   logic             room;
   logic             want_res;
   logic             stall;

   assign req_ready = (state_ff == S_IDLE) && (out_free || req_data.operation == OP_TICK);
   assign req_acc   = req_valid && req_ready;
   assign slot_ok   = 32'(req_data.slot) < 32'(NUM_SLOTS);
   assign slot_idx  = IDX_W'(req_data.slot);

   // Process stage of the sweep: read data for proc_idx_ff is on the memory outputs.
   assign query_idx = proc_idx_ff;
   assign proc_act  = (state_ff == S_SWEEP) && proc_valid_ff && in_use_q;
   assign cnt_zero  = (cnt_rdata == '0);
   assign cnt_fire  = (cnt_rdata == TIME_W'(1));
   assign room      = fire_cnt_ff < FIRE_CNT_W'(MAX_RESULTS);
   assign want_res  = proc_act && cnt_fire && room;
   // A second fire pushes the held one out; wait while the output is full.
   assign stall     = want_res && held_valid_ff && !out_free;

   always_comb begin
      mem_cmd    = '0;
      rd_addr    = issue_idx_ff;
      wr_addr    = proc_idx_ff;
      per_wdata  = TIME_W'(req_data.period);
      cnt_wdata  = TIME_W'(req_data.delay);
      prot_wdata = req_data.protect;
      alloc_cmd  = '0;
      alloc_idx  = proc_idx_ff;
      out_load   = 1'b0;
      out_data   = '0;

      state_in      = state_ff;
      issue_act_in  = issue_act_ff;
      issue_idx_in  = issue_idx_ff;
      proc_valid_in = proc_valid_ff;
      proc_idx_in   = proc_idx_ff;
      held_valid_in = held_valid_ff;
      held_slot_in  = held_slot_ff;
      fire_cnt_in   = fire_cnt_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (req_acc) begin
               unique case (req_data.operation)
                  OP_REGISTER: begin
                     wr_addr        = free_idx;
                     alloc_idx      = free_idx;
                     mem_cmd.per_we = free_found;
                     mem_cmd.cnt_we = free_found;
                     alloc_cmd.set  = free_found;
                     out_load       = 1'b1;
                     out_data.slot_number = free_found ? SLOT_FIELD_W'(free_idx) : '0;
                     out_data.accepted    = free_found;
                     out_data.last        = 1'b1;
                  end
                  OP_SET_PERIOD: begin
                     wr_addr        = slot_idx;
                     mem_cmd.per_we = slot_ok;
                     out_load       = 1'b1;
                     out_data.slot_number = req_data.slot;
                     out_data.accepted    = slot_ok;
                     out_data.last        = 1'b1;
                  end
                  OP_CANCEL: begin
                     wr_addr        = slot_idx;
                     cnt_wdata      = '0;
                     prot_wdata     = 1'b0;
                     mem_cmd.cnt_we = slot_ok;
                     out_load       = 1'b1;
                     out_data.slot_number = req_data.slot;
                     out_data.accepted    = slot_ok;
                     out_data.last        = 1'b1;
                  end
                  OP_TICK: begin
                     state_in      = S_SWEEP;
                     issue_act_in  = 1'b1;
                     issue_idx_in  = '0;
                     proc_valid_in = 1'b0;
                     held_valid_in = 1'b0;
                     fire_cnt_in   = '0;
                  end
                  default: ;
               endcase
            end
         end
         S_SWEEP: begin
            if (!stall) begin
               // Issue stage: read the next slot.
               mem_cmd.rd_en = issue_act_ff;
               proc_valid_in = issue_act_ff;
               proc_idx_in   = issue_idx_ff;
               if (issue_act_ff) begin
                  if (issue_idx_ff == LAST_IDX) begin
                     issue_act_in = 1'b0;
                  end else begin
                     issue_idx_in = issue_idx_ff + IDX_W'(1);
                  end
               end
               // Process stage: update count, free or fire.
               if (proc_act) begin
                  if (cnt_zero) begin
                     alloc_cmd.clear = !prot_rdata;
                  end else begin
                     mem_cmd.cnt_we = 1'b1;
                     prot_wdata     = prot_rdata;
                     cnt_wdata      = cnt_fire ? per_rdata : cnt_rdata - TIME_W'(1);
                  end
               end
               if (want_res) begin
                  out_load             = held_valid_ff;
                  out_data.slot_number = held_slot_ff;
                  out_data.accepted    = 1'b1;
                  out_data.fired       = 1'b1;
                  held_valid_in        = 1'b1;
                  held_slot_in         = SLOT_FIELD_W'(proc_idx_ff);
                  fire_cnt_in          = fire_cnt_ff + FIRE_CNT_W'(1);
               end
               if (!issue_act_ff && !proc_valid_ff) begin
                  state_in = S_FLUSH;
               end
            end
         end
         S_FLUSH: begin
            // Drain the held fire as the final item of the tick.
            if (!held_valid_ff) begin
               state_in = S_IDLE;
            end else if (out_free) begin
               out_load             = 1'b1;
               out_data.slot_number = held_slot_ff;
               out_data.accepted    = 1'b1;
               out_data.fired       = 1'b1;
               out_data.last        = 1'b1;
               held_valid_in        = 1'b0;
               state_in             = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         issue_act_ff  <= 1'b0;
         issue_idx_ff  <= '0;
         proc_valid_ff <= 1'b0;
         proc_idx_ff   <= '0;
         held_valid_ff <= 1'b0;
         fire_cnt_ff   <= '0;
      end else begin
         state_ff      <= state_in;
         issue_act_ff  <= issue_act_in;
         issue_idx_ff  <= issue_idx_in;
         proc_valid_ff <= proc_valid_in;
         proc_idx_ff   <= proc_idx_in;
         held_valid_ff <= held_valid_in;
         fire_cnt_ff   <= fire_cnt_in;
      end
      held_slot_ff <= held_slot_in;
   end

   `PTS_ASSERT_NOW(a_load_needs_room, out_load, out_free)
   `PTS_ASSERT_NOW(a_idle_no_held, state_ff == S_IDLE, !held_valid_ff)
   `PTS_ASSERT_NOW(a_fire_cap, 1'b1, fire_cnt_ff <= FIRE_CNT_W'(MAX_RESULTS))
   `PTS_ASSERT_NEXT(a_stall_holds_slot, stall, $stable(proc_idx_ff) && proc_valid_ff)

endmodule

FILE: hw/rtl/periodic_timer_slot_table_top.sv
// Top level of the periodic timer slot table: result register and submodule wiring.
// Depends on pts_pkg, pts_mem, pts_alloc and pts_seq.
`timescale 1ns / 1ps

// Periodic timer slot table. Register, set-period and cancel items are
// handled in the cycle they are accepted and return one result item each;
// they are taken when no tick is in progress and the result register is
// empty or being emptied. A tick item sweeps the slots in order through the
// memories' single read port, one slot per cycle while the result side does
// not stall, and holds req_ready low until the sweep is over: all slots are
// read, the last slot is finished, the empty pipeline is seen and any held
// fire is sent. It returns one item per firing slot (at most MAX_RESULTS,
// lowest slots first, last set on the final one) and nothing if no slot
// fires. Period, count and protect flag live in two memories with registered
// reads; the in-use bits are flops cleared by reset, so there is no clearing
// pass and the block takes items right after reset. Period and delay are
// cut or zero-extended to TIME_WIDTH.
module periodic_timer_slot_table_top #(
   parameter int NUM_SLOTS  = pts_pkg::NUM_SLOTS_DEFAULT,
   parameter int TIME_WIDTH = pts_pkg::TIME_WIDTH_DEFAULT
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  pts_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output pts_pkg::rsp_type rsp_data
);
   import pts_pkg::*;

   localparam int IDX_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;

   logic             rsp_valid_ff, rsp_valid_in;
   rsp_type          rsp_data_ff,  rsp_data_in;
   logic             out_free;
   logic             out_load;
   rsp_type          out_data;

   mem_cmd_type      mem_cmd;
   logic [IDX_W-1:0] rd_addr;
   logic [IDX_W-1:0] wr_addr;
   logic [TIME_WIDTH-1:0] per_wdata, cnt_wdata, per_rdata, cnt_rdata;
   logic             prot_wdata, prot_rdata;

   alloc_cmd_type    alloc_cmd;
   logic [IDX_W-1:0] alloc_idx;
   logic [IDX_W-1:0] query_idx;
   logic             in_use_q;
   logic             free_found;
   logic [IDX_W-1:0] free_idx;

   // Result register: the sequencer loads only when it is empty or draining.
   assign out_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (out_load) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = out_data;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // Period and count/protect storage.
   pts_mem #(
      .NUM_SLOTS (NUM_SLOTS),
      .TIME_W    (TIME_WIDTH),
      .IDX_W     (IDX_W)
   ) u_mem (
      .clock      (clock),
      .cmd        (mem_cmd),
      .rd_addr    (rd_addr),
      .wr_addr    (wr_addr),
      .per_wdata  (per_wdata),
      .cnt_wdata  (cnt_wdata),
      .prot_wdata (prot_wdata),
      .per_rdata  (per_rdata),
      .cnt_rdata  (cnt_rdata),
      .prot_rdata (prot_rdata)
   );

   // In-use bits and free-slot search.
   pts_alloc #(
      .NUM_SLOTS (NUM_SLOTS),
      .IDX_W     (IDX_W)
   ) u_alloc (
      .clock      (clock),
      .reset      (reset),
      .cmd        (alloc_cmd),
      .cmd_idx    (alloc_idx),
      .query_idx  (query_idx),
      .in_use_q   (in_use_q),
      .free_found (free_found),
      .free_idx   (free_idx)
   );

   // Operation decode and tick sweep.
   pts_seq #(
      .NUM_SLOTS (NUM_SLOTS),
      .TIME_W    (TIME_WIDTH),
      .IDX_W     (IDX_W)
   ) u_seq (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_data   (req_data),
      .req_ready  (req_ready),
      .out_free   (out_free),
      .out_load   (out_load),
      .out_data   (out_data),
      .mem_cmd    (mem_cmd),
      .rd_addr    (rd_addr),
      .wr_addr    (wr_addr),
      .per_wdata  (per_wdata),
      .cnt_wdata  (cnt_wdata),
      .prot_wdata (prot_wdata),
      .per_rdata  (per_rdata),
      .cnt_rdata  (cnt_rdata),
      .prot_rdata (prot_rdata),
      .alloc_cmd  (alloc_cmd),
      .alloc_idx  (alloc_idx),
      .query_idx  (query_idx),
      .in_use_q   (in_use_q),
      .free_found (free_found),
      .free_idx   (free_idx)
   );

endmodule

FILE: verif/tb_periodic_timer_slot_table_top.sv
// Self-checking testbench for periodic_timer_slot_table_top: register, set-period,
// cancel and tick items under random idling, checked against a slot table model.
// Depends on pts_pkg and the periodic_timer_slot_table_top RTL.
`timescale 1ns / 1ps

module tb_periodic_timer_slot_table_top;
   import pts_pkg::*;

   localparam int SLOTS           = NUM_SLOTS_DEFAULT;
   localparam int RANDOM_ITEMS    = 190;
   localparam int HOLD_OFF_CYCLES = 400;
   // A tick that fires nothing gives no result but still sweeps every slot.
   localparam int SETTLE_CYCLES   = 2 * SLOTS + 8;
   localparam int CYCLE_LIMIT     = 500000;
   localparam int PRINT_CAP       = 40;

   // Timer table model plus the queue of results it still expects.
   class timer_table_scoreboard;
      bit                      in_use[SLOTS];
      logic [TIME_FIELD_W-1:0] reload[SLOTS];
      logic [TIME_FIELD_W-1:0] countdown[SLOTS];
      bit                      keep[SLOTS];
      rsp_type                 expected_events[$];
      int unsigned             mismatches;
      int unsigned             items_noted;
      int unsigned             results_checked;
      int unsigned             fires_checked;
      int unsigned             full_rejects;

      function new();
         foreach (in_use[i]) begin
            in_use[i]    = 1'b0;
            reload[i]    = '0;
            countdown[i] = '0;
            keep[i]      = 1'b0;
         end
         mismatches      = 0;
         items_noted     = 0;
         results_checked = 0;
         fires_checked   = 0;
         full_rejects    = 0;
      endfunction

      function void push_event(logic [SLOT_FIELD_W-1:0] sl, bit acc, bit fire, bit fin);
         rsp_type e;
         e.slot_number = sl;
         e.accepted    = acc;
         e.fired       = fire;
         e.last        = fin;
         expected_events.push_back(e);
      endfunction

      // Apply one accepted item to the table and queue the results it causes.
      function void note_request(req_type r);
         bit          found;
         int unsigned fires;
         items_noted++;
         case (r.operation)
            OP_REGISTER: begin
               found = 1'b0;
               for (int i = 0; i < SLOTS && !found; i++) begin
                  if (!in_use[i]) begin
                     in_use[i]    = 1'b1;
                     reload[i]    = r.period;
                     countdown[i] = r.delay;
                     keep[i]      = r.protect;
                     found        = 1'b1;
                     push_event(SLOT_FIELD_W'(i), 1'b1, 1'b0, 1'b1);
                  end
               end
               if (!found) begin
                  full_rejects++;
                  push_event('0, 1'b0, 1'b0, 1'b1);
               end
            end
            OP_SET_PERIOD, OP_CANCEL: begin
               if (int'(r.slot) >= SLOTS) begin
                  push_event(r.slot, 1'b0, 1'b0, 1'b1);
               end else begin
                  if (r.operation == OP_SET_PERIOD) begin
                     reload[r.slot] = r.period;
                  end else begin
                     keep[r.slot]      = 1'b0;
                     countdown[r.slot] = '0;
                  end
                  push_event(r.slot, 1'b1, 1'b0, 1'b1);
               end
            end
            default: begin
               fires = 0;
               for (int i = 0; i < SLOTS; i++) begin
                  if (in_use[i]) begin
                     if (countdown[i] == '0) begin
                        if (!keep[i]) in_use[i] = 1'b0;
                     end else begin
                        countdown[i] = countdown[i] - 1'b1;
                        if (countdown[i] == '0) begin
                           countdown[i] = reload[i];
                           if (fires < MAX_RESULTS) begin
                              push_event(SLOT_FIELD_W'(i), 1'b1, 1'b1, 1'b0);
                              fires++;
                           end
                        end
                     end
                  end
               end
               if (fires != 0) expected_events[expected_events.size() - 1].last = 1'b1;
            end
         endcase
      endfunction

      task report_mismatch(string what);
         mismatches++;
         if (mismatches <= PRINT_CAP) $display("mismatch %0d: %s", mismatches, what);
      endtask

      // Compare one accepted result with the oldest expectation.
      task check_result(rsp_type got);
         rsp_type want;
         results_checked++;
         if (expected_events.size() == 0) begin
            report_mismatch($sformatf("result with none expected: slot %0d acc %0b fired %0b last %0b",
                                      got.slot_number, got.accepted, got.fired, got.last));
            return;
         end
         want = expected_events.pop_front();
         if (want.fired) fires_checked++;
         if (got.slot_number !== want.slot_number)
            report_mismatch($sformatf("slot_number %0d, expected %0d",
                                      got.slot_number, want.slot_number));
         if (got.accepted !== want.accepted)
            report_mismatch($sformatf("accepted %0b, expected %0b (slot %0d)",
                                      got.accepted, want.accepted, want.slot_number));
         if (got.fired !== want.fired)
            report_mismatch($sformatf("fired %0b, expected %0b (slot %0d)",
                                      got.fired, want.fired, want.slot_number));
         if (got.last !== want.last)
            report_mismatch($sformatf("last %0b, expected %0b (slot %0d)",
                                      got.last, want.last, want.slot_number));
      endtask
   endclass

   logic    clock = 1'b0;
   logic    reset;
   logic    req_valid;
   logic    req_ready;
   req_type req_data;
   logic    rsp_valid;
   logic    rsp_ready;
   rsp_type rsp_data;

   int unsigned send_idle_pct;
   int unsigned rsp_idle_pct;
   int unsigned holds_asked;
   int unsigned holds_served;
   int unsigned stall_left;

   timer_table_scoreboard sb;

   periodic_timer_slot_table_top DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   // 4 ns clock.
   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Result side: drive ready at the falling edge. A pending hold-off request
   // from the stimulus turns into a long run of low ready counted here.
   initial begin
      rsp_ready    = 1'b0;
      holds_served = 0;
      stall_left   = 0;
      forever begin
         @(negedge clock);
         if (holds_asked != holds_served) begin
            holds_served++;
            stall_left = HOLD_OFF_CYCLES;
         end
         if (reset) begin
            rsp_ready <= 1'b0;
         end else if (stall_left != 0) begin
            stall_left--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= ($urandom_range(99) >= rsp_idle_pct);
         end
      end
   end

   // Check every result item on the edge that accepts it.
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) sb.check_result(rsp_data);
   end

   // Hard stop in case the block hangs.
   initial begin
      repeat (CYCLE_LIMIT) @(posedge clock);
      $display("timeout after %0d cycles, %0d results still outstanding",
               CYCLE_LIMIT, sb.expected_events.size());
      $display("CHECK FAILED");
      $finish;
   end

   // Offer one item. Start at a falling edge, idle at random first, then hold
   // valid and payload until the rising edge that accepts the item.
   task send(op_type op, logic [SLOT_FIELD_W-1:0] sl, logic [TIME_FIELD_W-1:0] per,
             logic [TIME_FIELD_W-1:0] dly, logic prot);
      req_type it;
      it.operation = op;
      it.slot      = sl;
      it.period    = per;
      it.delay     = dly;
      it.protect   = prot;
      @(negedge clock);
      while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= it;
      do @(posedge clock); while (!req_ready);
      sb.note_request(it);
   endtask

   // Drop valid and wait until every expected result has arrived, then give a
   // silent tick sweep time to finish.
   task wait_for_drain();
      @(negedge clock);
      req_valid <= 1'b0;
      while (sb.expected_events.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Mostly short times so slots fire and recycle often; now and then any value.
   function logic [TIME_FIELD_W-1:0] rand_time();
      int unsigned v;
      v = $urandom_range(99);
      if (v < 75) return TIME_FIELD_W'($urandom_range(5));
      if (v < 90) return TIME_FIELD_W'($urandom_range(40));
      return TIME_FIELD_W'($urandom);
   endfunction

   // Loose mix of all four operations; ignored fields carry random bits.
   task send_random_item();
      int unsigned pick;
      pick = $urandom_range(99);
      if (pick < 30)
         send(OP_REGISTER, SLOT_FIELD_W'($urandom), rand_time(), rand_time(), 1'($urandom));
      else if (pick < 45)
         send(OP_SET_PERIOD, SLOT_FIELD_W'($urandom), rand_time(), TIME_FIELD_W'($urandom),
              1'($urandom));
      else if (pick < 55)
         send(OP_CANCEL, SLOT_FIELD_W'($urandom), TIME_FIELD_W'($urandom),
              TIME_FIELD_W'($urandom), 1'($urandom));
      else
         send(OP_TICK, SLOT_FIELD_W'($urandom), TIME_FIELD_W'($urandom),
              TIME_FIELD_W'($urandom), 1'($urandom));
   endtask

   // Random traffic built from short episodes: a loose mix, a batch of
   // registrations sharing one delay followed by enough ticks to fire them
   // together, or a round of cancels plus a tick to free slots again.
   task run_random(int unsigned count);
      int unsigned sent;
      int unsigned pick;
      int unsigned n;
      int unsigned d;
      logic [TIME_FIELD_W-1:0] p;
      sent = 0;
      while (sent < count) begin
         pick = $urandom_range(99);
         if (pick < 55) begin
            n = $urandom_range(8, 3);
            repeat (n) send_random_item();
            sent += n;
         end else if (pick < 80) begin
            n = $urandom_range(8, 1);
            d = $urandom_range(3, 1);
            p = TIME_FIELD_W'($urandom_range(4));
            repeat (n) send(OP_REGISTER, SLOT_FIELD_W'($urandom), p, TIME_FIELD_W'(d),
                            1'($urandom));
            repeat (d + 1) send(OP_TICK, SLOT_FIELD_W'($urandom), TIME_FIELD_W'($urandom),
                                TIME_FIELD_W'($urandom), 1'($urandom));
            sent += n + d + 1;
         end else begin
            n = $urandom_range(8, 2);
            repeat (n) send(OP_CANCEL, SLOT_FIELD_W'($urandom_range(SLOTS - 1)),
                            rand_time(), rand_time(), 1'($urandom));
            send(OP_TICK, SLOT_FIELD_W'($urandom), TIME_FIELD_W'($urandom),
                 TIME_FIELD_W'($urandom), 1'($urandom));
            sent += n + 1;
         end
      end
   endtask

   initial begin
      sb            = new();
      reset         = 1'b1;
      req_valid     = 1'b0;
      req_data      = '0;
      send_idle_pct = 0;
      rsp_idle_pct  = 0;
      holds_asked   = 0;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed part. Tick an empty table: expect no result.
      send(OP_TICK, '0, '0, '0, 1'b0);
      // Fill all slots: zero delay, zero period on a protected slot,
      // the largest times, and twelve slots that will fire on one tick.
      send(OP_REGISTER, '0, 16'h0000, 16'h0000, 1'b0);
      send(OP_REGISTER, '0, 16'h0000, 16'h0001, 1'b1);
      send(OP_REGISTER, '0, 16'hFFFF, 16'hFFFF, 1'b1);
      send(OP_REGISTER, '0, 16'h0002, 16'h0001, 1'b0);
      for (int i = 4; i < SLOTS; i++) begin
         send(OP_REGISTER, SLOT_FIELD_W'(i), 16'h0003, 16'h0002, 1'(i));
      end
      // Table full: expect a refusal.
      send(OP_REGISTER, 4'hF, 16'h5A5A, 16'hA5A5, 1'b1);
      send(OP_SET_PERIOD, 4'hF, 16'hA5A5, 16'h5A5A, 1'b0);
      // First tick frees slot 0 and fires slots 1 and 3; second fires twelve.
      send(OP_TICK, 4'hF, 16'hFFFF, 16'hFFFF, 1'b1);
      send(OP_TICK, '0, '0, '0, 1'b0);
      // Slot 1 idles protected; cancel it so the next tick frees it.
      send(OP_CANCEL, 4'h1, 16'hFFFF, 16'hFFFF, 1'b1);
      send(OP_TICK, '0, '0, '0, 1'b0);
      // Write a free slot, then take it again with register.
      send(OP_SET_PERIOD, 4'h0, 16'h1234, '0, 1'b0);
      send(OP_CANCEL, 4'h1, '0, '0, 1'b0);
      send(OP_REGISTER, '0, 16'h0001, 16'h0001, 1'b0);
      send(OP_TICK, '0, '0, '0, 1'b0);
      wait_for_drain();

      // Random part in three idling phases.
      send_idle_pct = 38;
      rsp_idle_pct  = 87;
      run_random(RANDOM_ITEMS / 3);
      wait_for_drain();

      // Back-pressure: stall the result side for a long stretch while the
      // sender keeps offering items, then pause until all results are in.
      send_idle_pct = 0;
      rsp_idle_pct  = 0;
      holds_asked++;
      for (int i = 0; i < 24; i++) begin
         if (i % 3 == 2)
            send(OP_CANCEL, SLOT_FIELD_W'($urandom), rand_time(), rand_time(), 1'($urandom));
         else
            send(OP_REGISTER, SLOT_FIELD_W'($urandom), rand_time(), rand_time(), 1'($urandom));
      end
      wait_for_drain();

      send_idle_pct = 87;
      rsp_idle_pct  = 38;
      run_random(RANDOM_ITEMS / 3);
      wait_for_drain();

      send_idle_pct = 0;
      rsp_idle_pct  = 0;
      run_random(RANDOM_ITEMS - 2 * (RANDOM_ITEMS / 3));
      wait_for_drain();

      $display("covered %0d items and %0d results: %0d slot fires, %0d refused registers",
               sb.items_noted, sb.results_checked, sb.fires_checked, sb.full_rejects);
      $display("idling sender/receiver 38/87, 87/38 and none, plus one long result stall");
      if (sb.mismatches == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
